// ----- rtl/core/bsi_pkg.sv -----
// shared types and constants for the boot stream interpreter
package bsi_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 2;
  localparam int unsigned SinkW = 4;
  localparam int unsigned CntW  = 16;
  localparam int unsigned BlW   = 2;

  // event kinds on the result channel
  localparam logic [KindW-1:0] KIND_CODE = 2'd0;
  localparam logic [KindW-1:0] KIND_DATA = 2'd1;
  localparam logic [KindW-1:0] KIND_DONE = 2'd2;

  // top two bits of a command byte
  localparam logic [1:0] CMD_LOAD_A = 2'b00;
  localparam logic [1:0] CMD_LOAD_B = 2'b01;
  localparam logic [1:0] CMD_SKIP   = 2'b10;
  localparam logic [1:0] CMD_CTRL   = 2'b11;

  // low two bits of a control command
  localparam logic [1:0] SEL_DEST_LO = 2'd0;
  localparam logic [1:0] SEL_DEST_HI = 2'd1;
  localparam logic [1:0] SEL_CNT_LO  = 2'd2;
  localparam logic [1:0] SEL_CNT_HI  = 2'd3;

  typedef enum logic [5:0] {
    ST_CMD     = 6'b000001,
    ST_LOAD    = 6'b000010,
    ST_DEST_LO = 6'b000100,
    ST_DEST_HI = 6'b001000,
    ST_CNT_LO  = 6'b010000,
    ST_CNT_HI  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] addr;
    logic [WordW-1:0] word;
  } result_t;

endpackage

// ----- rtl/core/bsi_interp.sv -----
// interpreter state and per-byte next-state logic
module bsi_interp import bsi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [ByteW-1:0] plain,
  output logic             res_valid,
  output result_t          res
);

  state_t            state_r, state_nxt;
  logic [SinkW-1:0]  sink_r, sink_nxt;
  logic [BlW-1:0]    bytes_left_r, bytes_left_nxt;
  logic [BlW-1:0]    bpw_r, bpw_nxt;
  logic [WordW-1:0]  acc_r, acc_nxt;
  logic [AddrW-1:0]  dest_r, dest_nxt;
  logic [CntW-1:0]   words_left_r, words_left_nxt;
  logic [WordW-1:0]  acc_shift;

  assign acc_shift = {acc_r[WordW-ByteW-1:0], plain};

  always_comb begin
    state_nxt      = state_r;
    sink_nxt       = sink_r;
    bytes_left_nxt = bytes_left_r;
    bpw_nxt        = bpw_r;
    acc_nxt        = acc_r;
    dest_nxt       = dest_r;
    words_left_nxt = words_left_r;
    res_valid      = 1'b0;
    res            = '0;
    unique case (state_r)
      ST_LOAD: begin
        if (bytes_left_r != '0) begin
          bytes_left_nxt = bytes_left_r - 1'b1;
          acc_nxt        = acc_shift;
        end else begin
          bytes_left_nxt = bpw_r;
          acc_nxt        = '0;
          // only code and data sinks produce writes
          if (sink_r[SinkW-1:1] == '0) begin
            res_valid = 1'b1;
            res.kind  = sink_r[0] ? KIND_DATA : KIND_CODE;
            res.addr  = dest_r;
            res.word  = acc_shift;
            dest_nxt  = dest_r + 1'b1;
          end
          if (words_left_r != '0) begin
            words_left_nxt = words_left_r - 1'b1;
          end else begin
            state_nxt = ST_CMD;
          end
        end
      end
      ST_DEST_HI: begin
        dest_nxt  = {plain, dest_r[ByteW-1:0]};
        state_nxt = ST_DEST_LO;
      end
      ST_DEST_LO: begin
        dest_nxt  = {dest_r[AddrW-1:ByteW], plain};
        state_nxt = ST_CMD;
      end
      ST_CNT_HI: begin
        words_left_nxt = {plain, words_left_r[ByteW-1:0]};
        state_nxt      = ST_CNT_LO;
      end
      ST_CNT_LO: begin
        words_left_nxt = {words_left_r[CntW-1:ByteW], plain};
        state_nxt      = ST_CMD;
      end
      default: begin
        unique case (plain[7:6])
          CMD_CTRL: begin
            if (plain[5]) begin
              // end of boot: report and clear everything
              res_valid      = 1'b1;
              res.kind       = KIND_DONE;
              state_nxt      = ST_CMD;
              sink_nxt       = '0;
              bytes_left_nxt = '0;
              bpw_nxt        = '0;
              acc_nxt        = '0;
              dest_nxt       = '0;
              words_left_nxt = '0;
            end else begin
              unique case (plain[1:0])
                SEL_DEST_LO: state_nxt = ST_DEST_LO;
                SEL_DEST_HI: state_nxt = ST_DEST_HI;
                SEL_CNT_LO:  state_nxt = ST_CNT_LO;
                SEL_CNT_HI:  state_nxt = ST_CNT_HI;
                default:     state_nxt = ST_CMD;
              endcase
            end
          end
          CMD_SKIP: begin
          end
          CMD_LOAD_A, CMD_LOAD_B: begin
            sink_nxt       = plain[5:2];
            bpw_nxt        = plain[1:0];
            bytes_left_nxt = plain[1:0];
            state_nxt      = ST_LOAD;
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CMD;
      sink_r       <= '0;
      bytes_left_r <= '0;
      bpw_r        <= '0;
      acc_r        <= '0;
      dest_r       <= '0;
      words_left_r <= '0;
    end else if (en) begin
      state_r      <= state_nxt;
      sink_r       <= sink_nxt;
      bytes_left_r <= bytes_left_nxt;
      bpw_r        <= bpw_nxt;
      acc_r        <= acc_nxt;
      dest_r       <= dest_nxt;
      words_left_r <= words_left_nxt;
    end
  end

endmodule

// ----- rtl/core/bsi_out_reg.sv -----
// result register with valid/stall handshake
module bsi_out_reg import bsi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  result_t          res,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KindW-1:0] out_event_kind,
  output logic [AddrW-1:0] out_write_address,
  output logic [WordW-1:0] out_write_word
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  // slot cannot take a new result while a held one is stalled
  assign busy      = valid_r & out_stall;
  assign valid_nxt = load | busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_event_kind    = data_r.kind;
  assign out_write_address = data_r.addr;
  assign out_write_word    = data_r.word;

endmodule

// ----- rtl/core/boot_stream_interpreter.sv -----
// top level of the boot stream interpreter
// a result reaches the out_ ports through the input register and then the result register
// throughput: one transaction per cycle, set by the decode loop, unless the output slot stalls a result
// a transaction that yields no result never waits on the output side
// reset: synchronous active-low rst_n empties both registers and returns to command mode
// all interpreter data (destination, count, word assembly) clears to zero at reset
module boot_stream_interpreter import bsi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] in_flash_byte,
  input  logic [ByteW-1:0] in_key_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [KindW-1:0] out_event_kind,
  output logic [AddrW-1:0] out_write_address,
  output logic [WordW-1:0] out_write_word
);

  // input register
  logic             s1_valid_r, s1_valid_nxt;
  logic [ByteW-1:0] flash_r;
  logic [ByteW-1:0] key_r;

  logic             in_accept;
  logic             s1_adv;
  logic             s1_fire;
  logic             res_valid;
  result_t          res;
  logic             out_busy;

  // the held byte moves on unless it has a result and the output slot is stuck
  assign s1_adv    = ~res_valid | ~out_busy;
  assign s1_fire   = s1_valid_r & s1_adv;
  assign in_stall  = s1_valid_r & ~s1_adv;
  assign in_accept = in_valid & ~in_stall;

  assign s1_valid_nxt = in_accept | (s1_valid_r & ~s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      flash_r <= in_flash_byte;
      key_r   <= in_key_byte;
    end
  end

  // decrypt, decode and update state in one pass
  bsi_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_fire),
    .plain     (flash_r ^ key_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register decouples the consumer from the decode stage
  bsi_out_reg u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (s1_fire & res_valid),
    .res               (res),
    .busy              (out_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_write_address (out_write_address),
    .out_write_word    (out_write_word)
  );

endmodule
